// ===== rtl/assert_macros.svh =====
// assertion helpers for the top-level rtl file, the one rtl file that checks itself
// all checks sample on i_clk and stay quiet while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RORF_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rorf check failed: same-cycle implication");

// consequent must hold in the cycle after the antecedent
`define RORF_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rorf check failed: next-cycle implication");

`endif

// ===== rtl/rorf_pkg.sv =====
`default_nettype none
package rorf_pkg;

    // canvas geometry
    localparam int MAX_SIDE      = 512;
    localparam int FRACTION_BITS = 8;
    localparam int SIDE_W        = $clog2(MAX_SIDE);
    localparam int DIM_W         = SIDE_W + 1;
    localparam int ADDR_W        = 2 * SIDE_W;
    localparam int CANVAS_DEPTH  = MAX_SIDE * MAX_SIDE;

    // fixed field widths
    localparam int CFG_DIM_W   = 10;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CHAR_W      = 8;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int RECT_POS_W  = 20;
    localparam int RECT_SIZE_W = 19;
    localparam int PIX_IDX_W   = 9;

    // input tdata layout, lowest field first
    localparam int OFF_X      = 0;
    localparam int OFF_Y      = OFF_X + RECT_POS_W;
    localparam int OFF_W      = OFF_Y + RECT_POS_W;
    localparam int OFF_H      = OFF_W + RECT_SIZE_W;
    localparam int OFF_CH     = OFF_H + RECT_SIZE_W;
    localparam int OFF_PX     = OFF_CH + CHAR_W;
    localparam int OFF_PY     = OFF_PX + PIX_IDX_W;
    localparam int IN_BITS    = OFF_PY + PIX_IDX_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = CHAR_W;

    // signed coordinate width: right edge sum plus outline margin, or pixel position
    localparam int EDGE_W  = RECT_POS_W + 2;
    localparam int PIXP_W  = SIDE_W + FRACTION_BITS + 1;
    localparam int COORD_W = (EDGE_W > PIXP_W) ? EDGE_W : PIXP_W;
    localparam int ONE     = 1 << FRACTION_BITS;

    // register reset values
    localparam logic [CFG_DIM_W-1:0] CANVAS_WIDTH_RESET  = CFG_DIM_W'(300);
    localparam logic [CFG_DIM_W-1:0] CANVAS_HEIGHT_RESET = CFG_DIM_W'(300);
    localparam logic [CHAR_W-1:0]    BACKGROUND_RESET    = CHAR_W'(32);

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 2'd0,
        OP_OUTLINE = 2'd1,
        OP_FILLED  = 2'd2,
        OP_READ    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_ZERO_SIZE = 2'd1,
        STAT_OUTSIDE   = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CANVAS_WIDTH  = 2'd0,
        CFG_CANVAS_HEIGHT = 2'd1,
        CFG_BACKGROUND    = 2'd2
    } t_cfg_index;

    // what the back end has to do with a queued command
    typedef enum logic [2:0] {
        CMD_CLEAR,
        CMD_FILLED,
        CMD_OUTLINE,
        CMD_READ,
        CMD_REPLY
    } t_kind;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SWEEP,
        BK_READ,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        t_kind                      kind;
        t_status                    status;
        logic [CHAR_W-1:0]          ch;
        logic [SIDE_W-1:0]          cols_m1;
        logic [SIDE_W-1:0]          rows_m1;
        logic signed [COORD_W-1:0]  x0;
        logic signed [COORD_W-1:0]  x0p;
        logic signed [COORD_W-1:0]  x1m;
        logic signed [COORD_W-1:0]  x1;
        logic signed [COORD_W-1:0]  y0;
        logic signed [COORD_W-1:0]  y0p;
        logic signed [COORD_W-1:0]  y1m;
        logic signed [COORD_W-1:0]  y1;
        logic [SIDE_W-1:0]          px;
        logic [SIDE_W-1:0]          py;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    typedef struct packed {
        logic busy;
        logic sweeping;
        logic wr_en;
    } t_back_stat;

    // active extent of one canvas axis, capped at the store size
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] d);
        logic [31:0] v;
        v = 32'(d);
        if (v > 32'(MAX_SIDE)) begin
            v = 32'(MAX_SIDE);
        end
        return DIM_W'(v);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rorf_front.sv =====
`default_nettype none
module rorf_front
    import rorf_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic [OP_W-1:0]        s_axis_tuser,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire t_queue_stat            i_q_stat,
    output logic                        o_q_push,
    output t_cmd                        o_q_cmd
);

    logic [CFG_DIM_W-1:0] r_canvas_w;
    logic [CFG_DIM_W-1:0] r_canvas_h;
    logic [CHAR_W-1:0]    r_bg_char;

    t_op                       op;
    logic [RECT_POS_W-1:0]     rect_x;
    logic [RECT_POS_W-1:0]     rect_y;
    logic [RECT_SIZE_W-1:0]    rect_w;
    logic [RECT_SIZE_W-1:0]    rect_h;
    logic [CHAR_W-1:0]         draw_char;
    logic [PIX_IDX_W-1:0]      pix_x;
    logic [PIX_IDX_W-1:0]      pix_y;
    logic [DIM_W-1:0]          cols;
    logic [DIM_W-1:0]          rows;
    logic                      empty_canvas;
    logic                      zero_size;
    logic                      read_inside;
    logic signed [COORD_W-1:0] one;
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;

    // config registers; the user must write them only while the block is idle, the block itself does not enforce it
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_w <= CANVAS_WIDTH_RESET;
            r_canvas_h <= CANVAS_HEIGHT_RESET;
            r_bg_char  <= BACKGROUND_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_CANVAS_WIDTH:  r_canvas_w <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_CANVAS_HEIGHT: r_canvas_h <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_BACKGROUND:    r_bg_char  <= i_cfg_data[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack the transfer
    assign op        = t_op'(s_axis_tuser);
    assign rect_x    = s_axis_tdata[OFF_X  +: RECT_POS_W];
    assign rect_y    = s_axis_tdata[OFF_Y  +: RECT_POS_W];
    assign rect_w    = s_axis_tdata[OFF_W  +: RECT_SIZE_W];
    assign rect_h    = s_axis_tdata[OFF_H  +: RECT_SIZE_W];
    assign draw_char = s_axis_tdata[OFF_CH +: CHAR_W];
    assign pix_x     = s_axis_tdata[OFF_PX +: PIX_IDX_W];
    assign pix_y     = s_axis_tdata[OFF_PY +: PIX_IDX_W];

    assign cols         = clamp_dim(r_canvas_w);
    assign rows         = clamp_dim(r_canvas_h);
    assign empty_canvas = (cols == '0) || (rows == '0);
    assign zero_size    = (rect_w == '0) || (rect_h == '0);
    assign read_inside  = (DIM_W'(pix_x) < cols) && (DIM_W'(pix_y) < rows);

    // rectangle bounds in the signed fixed point domain
    assign one = COORD_W'(ONE);
    assign x0  = COORD_W'($signed(rect_x));
    assign y0  = COORD_W'($signed(rect_y));
    assign x1  = x0 + COORD_W'(rect_w);
    assign y1  = y0 + COORD_W'(rect_h);

    always_comb begin
        o_q_cmd         = '0;
        o_q_cmd.cols_m1 = SIDE_W'(cols - DIM_W'(1));
        o_q_cmd.rows_m1 = SIDE_W'(rows - DIM_W'(1));
        o_q_cmd.x0      = x0;
        o_q_cmd.x0p     = x0 + one;
        o_q_cmd.x1m     = x1 - one;
        o_q_cmd.x1      = x1;
        o_q_cmd.y0      = y0;
        o_q_cmd.y0p     = y0 + one;
        o_q_cmd.y1m     = y1 - one;
        o_q_cmd.y1      = y1;
        o_q_cmd.px      = SIDE_W'(pix_x);
        o_q_cmd.py      = SIDE_W'(pix_y);
        o_q_cmd.status  = STAT_DONE;
        o_q_cmd.ch      = draw_char;
        case (op)
            OP_CLEAR: begin
                o_q_cmd.ch   = r_bg_char;
                o_q_cmd.kind = empty_canvas ? CMD_REPLY : CMD_CLEAR;
            end
            OP_READ: begin
                if (read_inside) begin
                    o_q_cmd.kind = CMD_READ;
                end else begin
                    o_q_cmd.kind   = CMD_REPLY;
                    o_q_cmd.status = STAT_OUTSIDE;
                end
            end
            default: begin
                if (zero_size) begin
                    o_q_cmd.kind   = CMD_REPLY;
                    o_q_cmd.status = STAT_ZERO_SIZE;
                end else if (empty_canvas) begin
                    o_q_cmd.kind = CMD_REPLY;
                end else if (op == OP_FILLED) begin
                    o_q_cmd.kind = CMD_FILLED;
                end else begin
                    o_q_cmd.kind = CMD_OUTLINE;
                end
            end
        endcase
    end

    assign s_axis_tready = !i_q_stat.full;
    assign o_q_push      = s_axis_tvalid && !i_q_stat.full;

endmodule
`default_nettype wire

// ===== rtl/rorf_queue.sv =====
`default_nettype none
module rorf_queue
    import rorf_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_cmd   i_cmd,
    input  wire logic   i_pop,
    output t_cmd        o_head,
    output t_queue_stat o_stat
);

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push;
    logic               do_pop;

    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/rorf_back.sv =====
`default_nettype none
module rorf_back
    import rorf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_queue_stat           i_q_stat,
    input  wire t_cmd                  i_head,
    output logic                       o_pop,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [STATUS_W-1:0]        m_axis_tuser,
    output t_back_stat                 o_stat
);

    logic [CHAR_W-1:0] r_canvas [CANVAS_DEPTH];
    logic [CHAR_W-1:0] r_rd_data;

    t_back_state       r_state;
    t_back_state       n_state;
    t_cmd              r_cmd;
    logic [SIDE_W-1:0] r_x;
    logic [SIDE_W-1:0] r_y;
    logic [CHAR_W-1:0] r_res_char;
    t_status           r_res_status;
    logic              r_m_valid;
    logic [CHAR_W-1:0] r_m_char;
    t_status           r_m_status;

    logic                      out_free;
    logic                      last_pixel;
    logic                      hit;
    logic                      wr_en;
    logic                      load_out;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ADDR_W-1:0]         rd_addr;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic                      in_x;
    logic                      in_y;
    logic                      near_x;
    logic                      near_y;

    // pixel coverage test for the current sweep position
    assign pos_x  = COORD_W'(r_x) << FRACTION_BITS;
    assign pos_y  = COORD_W'(r_y) << FRACTION_BITS;
    assign in_x   = (r_cmd.x0 <= pos_x) && (pos_x <= r_cmd.x1);
    assign in_y   = (r_cmd.y0 <= pos_y) && (pos_y <= r_cmd.y1);
    assign near_x = ((r_cmd.x0 <= pos_x) && (pos_x <= r_cmd.x0p))
                 || ((r_cmd.x1m <= pos_x) && (pos_x <= r_cmd.x1));
    assign near_y = ((r_cmd.y0 <= pos_y) && (pos_y <= r_cmd.y0p))
                 || ((r_cmd.y1m <= pos_y) && (pos_y <= r_cmd.y1));

    always_comb begin
        case (r_cmd.kind)
            CMD_CLEAR:   hit = 1'b1;
            CMD_FILLED:  hit = in_x && in_y;
            CMD_OUTLINE: hit = (near_x && in_y) || (near_y && in_x);
            default:     hit = 1'b0;
        endcase
    end

    assign last_pixel = (r_x == r_cmd.cols_m1) && (r_y == r_cmd.rows_m1);
    assign out_free   = !r_m_valid || m_axis_tready;
    assign wr_addr    = {r_y, r_x};
    assign rd_addr    = {i_head.py, i_head.px};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    case (i_head.kind)
                        CMD_READ:  n_state = BK_READ;
                        CMD_REPLY: n_state = BK_DONE;
                        default:   n_state = BK_SWEEP;
                    endcase
                end
            end
            BK_SWEEP: begin
                if (last_pixel) begin
                    n_state = BK_DONE;
                end
            end
            BK_READ:  n_state = BK_DONE;
            BK_DONE: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default:  n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop    = (r_state == BK_IDLE) && !i_q_stat.empty;
        wr_en    = (r_state == BK_SWEEP) && hit;
        load_out = (r_state == BK_DONE) && out_free;
    end

    assign o_stat.busy     = (r_state != BK_IDLE);
    assign o_stat.sweeping = (r_state == BK_SWEEP);
    assign o_stat.wr_en    = wr_en;

    // canvas store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_canvas[wr_addr] <= r_cmd.ch;
        end
        r_rd_data <= r_canvas[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd        <= i_head;
            r_x          <= '0;
            r_y          <= '0;
            r_res_char   <= '0;
            r_res_status <= i_head.status;
        end else if (r_state == BK_SWEEP) begin
            if (r_x == r_cmd.cols_m1) begin
                r_x <= '0;
                r_y <= r_y + SIDE_W'(1);
            end else begin
                r_x <= r_x + SIDE_W'(1);
            end
        end else if (r_state == BK_READ) begin
            r_res_char <= r_rd_data;
        end
        if (load_out) begin
            r_m_char   <= r_res_char;
            r_m_status <= r_res_status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_char;
    assign m_axis_tuser  = r_m_status;

endmodule
`default_nettype wire

// ===== rtl/rectangle_outline_fill_rasterizer.sv =====
`default_nettype none
`include "assert_macros.svh"
// Character canvas rasterizer for axis-aligned rectangles. Each input transfer
// carries one operation: clear (fill the active canvas with the background
// character), outline draw, filled draw, or a pixel read; every operation
// returns exactly one result transfer with the read character (zero unless a
// successful read) and a status (done, zero-size draw rejected, read outside
// the active canvas). Rectangle coordinates are signed Q11.8 and sizes are
// unsigned Q11.8; pixel (x, y) sits at x.0, y.0 and a rectangle covers the
// closed range [x, x+w] by [y, y+h]. An outline keeps only pixels within one
// unit of an edge. The front end decodes and classifies each transfer into a
// two-entry command queue; the back end owns the 512 x 512 canvas memory and
// walks every active pixel, one memory write port access per cycle. The back
// end sweeps a clear or draw pixel by pixel, passes a read through the
// registered memory read and its read state, and takes a rejected or
// empty-canvas operation straight to its done state, where each result waits
// until the result register is free, which m_axis_tready can delay. The front
// end keeps accepting up to two commands while the back end sweeps. The canvas
// has no reset clear: read only pixels that a clear or draw has written. Canvas
// width and height above 512 act as 512; configuration may only be written
// while no operation is in flight.
module rectangle_outline_fill_rasterizer
    import rorf_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // rect_x[19:0] rect_y[39:20] rect_width[58:40] rect_height[77:59]
    // draw_char[85:78] pixel_x[94:86] pixel_y[103:95]
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
    // operation[1:0]
    input  wire logic [OP_W-1:0]        s_axis_tuser,
    // result stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // pixel_char[7:0]
    output logic [OUT_DATA_W-1:0]       m_axis_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]         m_axis_tuser,
    // config write channel: 0 canvas_width, 1 canvas_height, 2 background_char
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // front to queue
    logic        q_push;
    t_cmd        q_cmd;
    // queue to back
    t_cmd        q_head;
    logic        q_pop;
    t_queue_stat q_stat;
    t_back_stat  b_stat;

    // decode, config registers and classification
    rorf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_stat      (q_stat),
        .o_q_push      (q_push),
        .o_q_cmd       (q_cmd)
    );

    // short command queue decoupling the two sides
    rorf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    // pixel sweep, canvas memory and result register
    rorf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_stat      (q_stat),
        .i_head        (q_head),
        .o_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_stat        (b_stat)
    );

    // a rejected result always carries a zero character
    `RORF_ASSERT_IMPL(a_reject_char_zero, m_axis_tvalid && (m_axis_tuser != STAT_DONE), m_axis_tdata == '0)
    // the front end never pushes into a full queue
    `RORF_ASSERT_IMPL(a_no_overflow, q_push, !q_stat.full)
    // a popped command always puts the back end to work
    `RORF_ASSERT_NEXT(a_pop_starts_work, q_pop, b_stat.busy)
    // the canvas is only written during a sweep
    `RORF_ASSERT_IMPL(a_write_in_sweep, b_stat.wr_en, b_stat.sweeping)

endmodule
`default_nettype wire

// ===== verif/rectangle_outline_fill_rasterizer_tb.sv =====
`timescale 1ns / 1ps
module rectangle_outline_fill_rasterizer_tb;
    import rorf_pkg::*;

    // 4 ns clock; generous run limit, well above the slowest correct run
    localparam int CLK_HALF_NS   = 2;
    localparam int RUN_LIMIT_NS  = 8_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 75;
    localparam int MAX_REPORTS   = 50;

    // one operation as it travels on the input stream
    typedef struct {
        t_op                           op;
        logic signed [RECT_POS_W-1:0]  rect_x;
        logic signed [RECT_POS_W-1:0]  rect_y;
        logic [RECT_SIZE_W-1:0]        rect_w;
        logic [RECT_SIZE_W-1:0]        rect_h;
        logic [CHAR_W-1:0]             draw_char;
        logic [PIX_IDX_W-1:0]          pixel_x;
        logic [PIX_IDX_W-1:0]          pixel_y;
    } t_raster_cmd;

    // one result transfer
    typedef struct {
        logic [CHAR_W-1:0] pixel_char;
        t_status           status;
    } t_pixel_reply;

    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata  = '0;
    logic [OP_W-1:0]         s_axis_tuser  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic [STATUS_W-1:0]     m_axis_tuser;
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;

    // mirror of the canvas and the registers, kept in step with accepted transfers
    logic [CHAR_W-1:0]       canvas_mirror [CANVAS_DEPTH];
    bit                      painted [CANVAS_DEPTH];
    logic [CFG_DIM_W-1:0]    cfg_cols = CANVAS_WIDTH_RESET;
    logic [CFG_DIM_W-1:0]    cfg_rows = CANVAS_HEIGHT_RESET;
    logic [CHAR_W-1:0]       cfg_bg   = BACKGROUND_RESET;

    t_pixel_reply            expected_replies [$];
    int                      mismatches      = 0;
    int                      replies_checked = 0;
    int                      settings_used   = 0;
    int                      op_tally [4]    = '{0, 0, 0, 0};
    bit                      steady          = 1'b0;  // no idling on either side
    int                      hold_left       = 0;

    rectangle_outline_fill_rasterizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // canvas predictor
    // ------------------------------------------------------------------

    // register values above the store size act as the store size
    function automatic int active_cols();
        return (cfg_cols > MAX_SIDE) ? MAX_SIDE : int'(cfg_cols);
    endfunction

    function automatic int active_rows();
        return (cfg_rows > MAX_SIDE) ? MAX_SIDE : int'(cfg_rows);
    endfunction

    function automatic bit spans(longint p, longint lo, longint hi);
        return (lo <= p) && (p <= hi);
    endfunction

    function automatic void paint(int x, int y, logic [CHAR_W-1:0] v);
        canvas_mirror[y * MAX_SIDE + x] = v;
        painted[y * MAX_SIDE + x]       = 1'b1;
    endfunction

    // updates the mirror for one operation and returns the result it must give
    function automatic t_pixel_reply apply_to_canvas(t_raster_cmd c);
        t_pixel_reply r;
        int           cols;
        int           rows;
        longint       one_px;
        longint       x0, y0, x1, y1, px, py;
        bit           in_x, in_y, near_x, near_y, hit;
        cols         = active_cols();
        rows         = active_rows();
        one_px       = longint'(ONE);
        r.pixel_char = '0;
        r.status     = STAT_DONE;
        case (c.op)
            OP_CLEAR: begin
                for (int y = 0; y < rows; y++)
                    for (int x = 0; x < cols; x++)
                        paint(x, y, cfg_bg);
            end
            OP_READ: begin
                if (int'(c.pixel_x) >= cols || int'(c.pixel_y) >= rows)
                    r.status = STAT_OUTSIDE;
                else
                    r.pixel_char = canvas_mirror[int'(c.pixel_y) * MAX_SIDE + int'(c.pixel_x)];
            end
            default: begin
                // exact arithmetic: sign-extended corners, zero-extended sizes
                x0 = longint'(c.rect_x);
                y0 = longint'(c.rect_y);
                x1 = x0 + longint'(c.rect_w);
                y1 = y0 + longint'(c.rect_h);
                if (c.rect_w == '0 || c.rect_h == '0) begin
                    r.status = STAT_ZERO_SIZE;
                end else begin
                    for (int y = 0; y < rows; y++) begin
                        py = longint'(y) * one_px;
                        for (int x = 0; x < cols; x++) begin
                            px     = longint'(x) * one_px;
                            in_x   = spans(px, x0, x1);
                            in_y   = spans(py, y0, y1);
                            near_x = spans(px, x0, x0 + one_px) || spans(px, x1 - one_px, x1);
                            near_y = spans(py, y0, y0 + one_px) || spans(py, y1 - one_px, y1);
                            if (c.op == OP_FILLED)
                                hit = in_x && in_y;
                            else
                                hit = (near_x && in_y) || (near_y && in_x);
                            if (hit)
                                paint(x, y, c.draw_char);
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_raster_cmd make_cmd(t_op op, int x, int y, int w, int h,
                                             int chr, int px, int py);
        t_raster_cmd c;
        c.op        = op;
        c.rect_x    = RECT_POS_W'(x);
        c.rect_y    = RECT_POS_W'(y);
        c.rect_w    = RECT_SIZE_W'(w);
        c.rect_h    = RECT_SIZE_W'(h);
        c.draw_char = CHAR_W'(chr);
        c.pixel_x   = PIX_IDX_W'(px);
        c.pixel_y   = PIX_IDX_W'(py);
        return c;
    endfunction

    // rectangle side: mostly spanning part of the canvas, sometimes zero or sub-pixel
    function automatic int random_span(int extent);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 0;
        else if (pick == 1)
            return $urandom_range(1, ONE - 1);
        else if (pick == 2)
            return ONE;
        return $urandom_range(1, (extent + 4) * ONE);
    endfunction

    // random operation; fields that the operation ignores carry noise
    function automatic t_raster_cmd random_cmd();
        t_raster_cmd c;
        int          cols;
        int          rows;
        int          pick;
        cols = active_cols();
        rows = active_rows();
        pick = $urandom_range(0, 19);
        c = make_cmd(OP_READ, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
        if (pick < 8)
            c.op = OP_FILLED;
        else if (pick < 14)
            c.op = OP_OUTLINE;
        else if (pick < 19)
            c.op = OP_READ;
        else
            c.op = OP_CLEAR;

        if (c.op == OP_READ) begin
            if (cols > 0 && rows > 0 && $urandom_range(0, 4) != 0) begin
                c.pixel_x = PIX_IDX_W'($urandom_range(0, cols - 1));
                c.pixel_y = PIX_IDX_W'($urandom_range(0, rows - 1));
            end
            // never ask for a pixel that nothing has written
            if (int'(c.pixel_x) < cols && int'(c.pixel_y) < rows &&
                !painted[int'(c.pixel_y) * MAX_SIDE + int'(c.pixel_x)]) begin
                c.pixel_x = '0;
                c.pixel_y = '0;
            end
        end else if (c.op != OP_CLEAR && $urandom_range(0, 6) != 0) begin
            // draws near the active area, with random sub-pixel offsets
            c.rect_x = RECT_POS_W'(int'($urandom_range(0, (cols + 6) * ONE)) - 3 * ONE);
            c.rect_y = RECT_POS_W'(int'($urandom_range(0, (rows + 6) * ONE)) - 3 * ONE);
            c.rect_w = RECT_SIZE_W'(random_span(cols));
            c.rect_h = RECT_SIZE_W'(random_span(rows));
        end
        return c;
    endfunction

    // one input transfer; valid stays high when no gap follows
    task automatic send_cmd(t_raster_cmd c);
        int gap;
        int pick;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.op;
        s_axis_tdata  <= IN_DATA_W'({c.pixel_y, c.pixel_x, c.draw_char, c.rect_h,
                                     c.rect_w, c.rect_y, c.rect_x});
        do @(posedge i_clk); while (!s_axis_tready);
        expected_replies.push_back(apply_to_canvas(c));
        op_tally[int'(c.op)]++;
        gap  = 0;
        pick = $urandom_range(0, 9);
        if (!steady && pick >= 5)
            gap = (pick == 9) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drop valid and let every outstanding result come back
    task automatic wait_for_idle();
        if (s_axis_tvalid) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        while (expected_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // one config transfer; valid is held across a burst and dropped after the closing one
    task automatic write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] val, bit closing);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_CANVAS_WIDTH:  cfg_cols = val;
            CFG_CANVAS_HEIGHT: cfg_rows = val;
            default:           cfg_bg   = val[CHAR_W-1:0];
        endcase
        if (closing)
            i_cfg_valid <= 1'b0;
    endtask

    task automatic set_canvas(int cols, int rows, int bg);
        wait_for_idle();
        write_reg(CFG_CANVAS_WIDTH, CFG_DATA_W'(cols), 1'b0);
        write_reg(CFG_CANVAS_HEIGHT, CFG_DATA_W'(rows), 1'b0);
        write_reg(CFG_BACKGROUND, CFG_DATA_W'(bg), 1'b1);
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, mostly short, a few long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!steady && $urandom_range(0, 7) == 0)
                hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 3);
        end
    end

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // each result transfer against the oldest outstanding expectation
    always @(posedge i_clk) begin : check_replies
        t_pixel_reply want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_replies.size() == 0) begin
                report_mismatch($sformatf(
                    "result transfer with nothing outstanding (char %0d status %0d)",
                    m_axis_tdata, m_axis_tuser));
            end else begin
                want = expected_replies.pop_front();
                replies_checked++;
                if (m_axis_tdata !== want.pixel_char)
                    report_mismatch($sformatf(
                        "result %0d pixel_char got %0d expected %0d",
                        replies_checked, m_axis_tdata, want.pixel_char));
                if (m_axis_tuser !== want.status)
                    report_mismatch($sformatf(
                        "result %0d status got %0d expected %0d",
                        replies_checked, m_axis_tuser, want.status));
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset canvas is 300 x 300 with a space background; no sweep of the full area
    task automatic test_reset_values();
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 300, 0));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 300));
        wait_for_idle();
        // narrow to one column so the clear stays short; height and background keep reset
        write_reg(CFG_CANVAS_WIDTH, CFG_DATA_W'(1), 1'b1);
        send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 299));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 300));
    endtask

    // every operation on a small canvas, plus field extremes and zero sizes
    task automatic test_draw_operations();
        set_canvas(16, 12, 8'h2E);
        // clear ignores the rectangle and pixel fields
        send_cmd(make_cmd(OP_CLEAR, -1, -1, -1, -1, 8'hFF, 511, 511));
        // far-off corner with maximum size covers the whole canvas
        send_cmd(make_cmd(OP_FILLED, -25600, -25600, 524287, 524287, 8'h00, 0, 0));
        send_cmd(make_cmd(OP_FILLED, 640, 256, 1088, 768, 8'h46, 0, 0));
        // outline partly off the top-left edge
        send_cmd(make_cmd(OP_OUTLINE, -384, -128, 2560, 2240, 8'hFF, 0, 0));
        // outline narrower than one pixel fills its whole column
        send_cmd(make_cmd(OP_OUTLINE, 3072, 512, 128, 1536, 8'h7C, 0, 0));
        // most negative corner: right edge lands at -1, nothing is covered
        send_cmd(make_cmd(OP_FILLED, -524288, -524288, 524287, 524287, 8'h55, 0, 0));
        send_cmd(make_cmd(OP_FILLED, 524287, 524287, 1, 1, 8'hAA, 0, 0));
        // zero width and zero height are rejected
        send_cmd(make_cmd(OP_OUTLINE, 0, 0, 0, 524287, 8'h11, 0, 0));
        send_cmd(make_cmd(OP_FILLED, 0, 0, 524287, 0, 8'h22, 0, 0));
        send_cmd(make_cmd(OP_READ, -1, -1, -1, -1, 8'hFF, 3, 1));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 15, 11));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 16, 11));
    endtask

    // empty canvas, oversized width, and the tallest canvas
    task automatic test_canvas_limits();
        set_canvas(0, 5, 8'h00);
        send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_FILLED, 0, 0, 256, 256, 8'h41, 0, 0));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        // 1023 columns act as 512
        set_canvas(1023, 1, 8'hFF);
        send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_OUTLINE, 0, 0, 511 * ONE, ONE, 8'h2A, 0, 0));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 511, 0));
        set_canvas(1, 512, 8'h20);
        send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 511));
    endtask

    // phases of random traffic, each on a fresh canvas setting that starts with a clear
    task automatic test_random_traffic();
        int sent;
        int phase_len;
        int cols;
        int rows;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0: begin
                    cols = $urandom_range(0, 1) ? 1023 : 512;
                    rows = $urandom_range(1, 3);
                end
                1: begin
                    cols = $urandom_range(1, 3);
                    rows = $urandom_range(0, 1) ? 1023 : 512;
                end
                2: begin
                    cols = $urandom_range(0, 1) ? 0 : $urandom_range(1, 24);
                    rows = (cols == 0) ? $urandom_range(0, 24) : 0;
                end
                default: begin
                    cols = $urandom_range(1, 24);
                    rows = $urandom_range(1, 24);
                end
            endcase
            set_canvas(cols, rows, $urandom_range(0, 255));
            steady = ($urandom_range(0, 3) == 0);
            send_cmd(make_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom));
            phase_len = $urandom_range(6, 14);
            repeat (phase_len)
                send_cmd(random_cmd());
            sent += phase_len + 1;
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_draw_operations();
        test_canvas_limits();
        test_random_traffic();
        wait_for_idle();
        // catch any stray result after the last expected one
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d clears, %0d outlines, %0d filled draws and %0d reads",
                 op_tally[OP_CLEAR], op_tally[OP_OUTLINE], op_tally[OP_FILLED],
                 op_tally[OP_READ]);
        $display("on %0d canvas settings; checked %0d results, %0d mismatches",
                 settings_used + 1, replies_checked, mismatches);
        if (mismatches == 0) begin
            $display("rectangle_outline_fill_rasterizer regression: pass");
        end else begin
            $display("rectangle_outline_fill_rasterizer regression: fail");
        end
        $finish;
    end

    // hang guard
    initial begin
        #RUN_LIMIT_NS;
        $display("timeout with %0d results outstanding", expected_replies.size());
        $display("rectangle_outline_fill_rasterizer regression: fail");
        $finish;
    end

endmodule
